@@ src/bpc_pkg.sv @@
// Shared constants and types for the barometric pressure compensation block.
package bpc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int OUT_BITS_DEF  = 18;

   localparam int RAW_TEMP_W  = 16;
   localparam int RAW_PRESS_W = 24;
   localparam int COEFF_W     = 16;
   localparam int COEFF_NUM   = 4;
   localparam int CSR_IDX_W   = 2;

   localparam int T_OFFSET     = 32768;
   localparam int TT_W         = 31;   // t*t <= 2^30
   localparam int QPROD_W      = COEFF_W + TT_W;
   localparam int QUAD_SHIFT   = 24;
   localparam int OFFSET_SHIFT = 11;   // middle offset is coeff * 2048

   localparam longint unsigned LOW_POINT_RAW  = 64'd3670016;
   localparam longint unsigned HIGH_POINT_RAW = 64'd12058624;

   localparam logic [COEFF_W-1:0] OTP_RESET = 16'h013D;

   // fit constants: base pressure, 7*12*5000, and the denominator weights
   localparam int P_BASE    = 45000;
   localparam int NUM_SCALE = 420000;
   localparam int DEN_UV    = 5;
   localparam int DEN_VW    = 7;
   localparam int DEN_UW    = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF_0 = 2'd0,
      CSR_COEFF_1 = 2'd1,
      CSR_COEFF_2 = 2'd2,
      CSR_COEFF_3 = 2'd3
   } bpc_csr_type;

   // status carried alongside the divider operands
   typedef struct packed {
      logic neg;   // quotient is subtracted from the base pressure
      logic bad;   // degenerate fit or zero denominator
      logic sat;   // quotient too large for the output range
   } bpc_side_type;

endpackage

@@ src/bpc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
module bpc_div #(
   parameter int NW = 110,
   parameter int DW = 96,
   parameter int QB = 19
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [NW-1:0]         in_num,
   input  logic [DW-1:0]         in_den,
   input  bpc_pkg::bpc_side_type in_side,
   output logic                  out_valid,
   output logic [QB-1:0]         out_quot,
   output logic                  out_rem_nz,
   output bpc_pkg::bpc_side_type out_side
);
   import bpc_pkg::*;

   localparam int CW = (NW > DW) ? NW : DW;

   logic         valid_ff [QB+1];
   logic [DW-1:0] rem_ff  [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic [QB-1:0] lo_ff   [QB+1];
   logic [QB-1:0] quot_ff [QB+1];
   bpc_side_type  side_ff [QB+1];

   logic          ovf;
   bpc_side_type  side_in;

   // quotient of 2^QB or more cannot land in range
   always_comb begin
      ovf         = (CW'(in_num >> QB) >= CW'(in_den));
      side_in     = in_side;
      side_in.sat = ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(in_num >> QB);
         den_ff[0]  <= in_den;
         lo_ff[0]   <= in_num[QB-1:0];
         quot_ff[0] <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_stage
      logic [DW:0] trial;
      logic        fits;

      always_comb begin
         trial = {rem_ff[i-1], lo_ff[i-1][QB-i]};
         fits  = (trial >= {1'b0, den_ff[i-1]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= fits ? DW'(trial - {1'b0, den_ff[i-1]}) : DW'(trial);
            den_ff[i]  <= den_ff[i-1];
            lo_ff[i]   <= lo_ff[i-1];
            quot_ff[i] <= {quot_ff[i-1][QB-2:0], fits};
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid  = valid_ff[QB];
   assign out_quot   = quot_ff[QB];
   assign out_rem_nz = (rem_ff[QB] != '0);
   assign out_side   = side_ff[QB];

endmodule

@@ src/baro_pressure_compensate_top.sv @@
// Top level of the barometric pressure compensation pipeline.
//
// Usage:
//  - Request channel (req_*): raw temperature and raw 24-bit pressure, one
//    transaction per sample, valid/ready handshake.
//  - Response channel (rsp_*): compensated pressure in pascals plus an
//    out_of_range flag, exactly one response per request, in order.
//  - CSR port (csr_*): four 16-bit factory calibration words, written with
//    csr_wr_en/csr_index/csr_wdata; only change them while the pipe is empty.
//  - Throughput: one transaction per cycle while the receiver takes results.
//  - Pipeline: the path from request to response holds OUT_BITS + 11
//    registers: 8 arithmetic stages, OUT_BITS + 2 divider stages (one
//    quotient bit each after the first) and the response register; the
//    first loads on the accepting edge itself.
//  - A receiver stall freezes the whole pipe; req_ready drops only while a
//    response is held and not taken, so nothing is lost or duplicated.
//  - Reset clears all valid bits and loads every calibration word with 0x013D.
module baro_pressure_compensate_top #(
   parameter int FRAC_BITS = bpc_pkg::FRAC_BITS_DEF,
   parameter int OUT_BITS  = bpc_pkg::OUT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bpc_pkg::RAW_TEMP_W-1:0]  req_raw_temp,
   input  logic [bpc_pkg::RAW_PRESS_W-1:0] req_raw_press,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [OUT_BITS-1:0]             rsp_pressure_pa,
   output logic                            rsp_out_of_range,
   input  logic                            csr_wr_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::COEFF_W-1:0]     csr_wdata
);
   import bpc_pkg::*;

   // look-up values are below 2^(28+FRAC_BITS)
   localparam int LW  = 28 + FRAC_BITS;
   localparam int N   = LW + 1;          // signed fit operands
   localparam int S   = (N + 1) / 2;     // partial product split
   localparam int H   = N - S;
   localparam int PW  = 2 * N;           // full products
   localparam int NW  = PW + 19;         // numerator, times 420000
   localparam int DW  = PW + 5;          // denominator
   localparam int QB  = OUT_BITS + 1;    // quotient bits kept
   localparam int QSH = QUAD_SHIFT - FRAC_BITS;

   localparam logic [LW-1:0] L0_BASE = LW'(LOW_POINT_RAW << FRAC_BITS);
   localparam logic [LW-1:0] L2_BASE = LW'(HIGH_POINT_RAW << FRAC_BITS);
   localparam logic signed [RAW_TEMP_W:0] T_OFF = (RAW_TEMP_W+1)'(T_OFFSET);
   localparam logic signed [NW-1:0] K_NUM = NW'(NUM_SCALE);
   localparam logic signed [DW-1:0] K_UV  = DW'(DEN_UV);
   localparam logic signed [DW-1:0] K_VW  = DW'(DEN_VW);
   localparam logic signed [DW-1:0] K_UW  = DW'(DEN_UW);
   localparam logic signed [N+3:0]  K_VW_S = (N+4)'(DEN_VW);
   localparam logic signed [N+3:0]  K_UW_S = (N+4)'(DEN_UW);
   localparam logic [QB:0] P_MAX  = (QB+1)'({OUT_BITS{1'b1}});
   localparam logic [QB:0] P_BASE_Q = (QB+1)'(P_BASE);

   // global advance: the pipe moves unless a held response is stalled
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- calibration registers ----------------
   logic [COEFF_W-1:0] coeff_ff [COEFF_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COEFF_NUM; k++) begin
            coeff_ff[k] <= OTP_RESET;
         end
      end else if (csr_wr_en) begin
         case (bpc_csr_type'(csr_index))
            CSR_COEFF_0: coeff_ff[0] <= csr_wdata;
            CSR_COEFF_1: coeff_ff[1] <= csr_wdata;
            CSR_COEFF_2: coeff_ff[2] <= csr_wdata;
            CSR_COEFF_3: coeff_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- valid chain ----------------
   logic [7:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], req_valid};
      end
   end

   // ---------------- stage 1: t and t^2 ----------------
   logic signed [RAW_TEMP_W:0]     t_in;
   logic signed [2*RAW_TEMP_W+1:0] t_sq;
   logic [TT_W-1:0]                tt1_ff;
   logic [RAW_PRESS_W-1:0]         rp1_ff;

   always_comb begin
      t_in = $signed({1'b0, req_raw_temp}) - T_OFF;
      t_sq = t_in * t_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tt1_ff <= t_sq[TT_W-1:0];
         rp1_ff <= req_raw_press;
      end
   end

   // ---------------- stage 2: curvature products ----------------
   logic [QPROD_W-1:0]     q0_ff, q1_ff, q2_ff;
   logic [RAW_PRESS_W-1:0] rp2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff  <= coeff_ff[0] * tt1_ff;
         q1_ff  <= coeff_ff[1] * tt1_ff;
         q2_ff  <= coeff_ff[2] * tt1_ff;
         rp2_ff <= rp1_ff;
      end
   end

   // ---------------- stage 3: look-up values ----------------
   logic [LW-1:0]          l0_ff, l1_ff, l2_ff;
   logic [RAW_PRESS_W-1:0] rp3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         l0_ff  <= L0_BASE + LW'(q0_ff >> QSH);
         l1_ff  <= (LW'(coeff_ff[3]) << (OFFSET_SHIFT + FRAC_BITS)) + LW'(q1_ff >> QSH);
         l2_ff  <= L2_BASE + LW'(q2_ff >> QSH);
         rp3_ff <= rp2_ff;
      end
   end

   // ---------------- stage 4: fit differences ----------------
   logic signed [N-1:0] u4_ff, v4_ff, w4_ff, vu4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u4_ff  <= $signed(N'(l1_ff)) - $signed(N'(l0_ff));
         v4_ff  <= $signed(N'(l2_ff)) - $signed(N'(l0_ff));
         vu4_ff <= $signed(N'(l2_ff)) - $signed(N'(l1_ff));
         w4_ff  <= $signed(N'(rp3_ff) << FRAC_BITS) - $signed(N'(l0_ff));
      end
   end

   // ---------------- stage 5: partial products ----------------
   // product order: w*(v-u), u*v, v*w, u*w
   logic signed [N-1:0]     opa [4];
   logic signed [N-1:0]     opb [4];
   logic signed [2*H-1:0]   hh_ff [4];
   logic signed [H+S:0]     hl_ff [4];
   logic signed [H+S:0]     lh_ff [4];
   logic [2*S-1:0]          ll_ff [4];
   logic                    degen5_ff;

   always_comb begin
      opa[0] = w4_ff; opb[0] = vu4_ff;
      opa[1] = u4_ff; opb[1] = v4_ff;
      opa[2] = v4_ff; opb[2] = w4_ff;
      opa[3] = u4_ff; opb[3] = w4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            hh_ff[k] <= $signed(opa[k][N-1:S]) * $signed(opb[k][N-1:S]);
            hl_ff[k] <= $signed(opa[k][N-1:S]) * $signed({1'b0, opb[k][S-1:0]});
            lh_ff[k] <= $signed({1'b0, opa[k][S-1:0]}) * $signed(opb[k][N-1:S]);
            ll_ff[k] <= opa[k][S-1:0] * opb[k][S-1:0];
         end
         // degenerate fit: coincident lower and middle points (u == 0) or 7*v == 12*u
         degen5_ff <= (u4_ff == '0) ||
                      ((N+4)'(v4_ff) * K_VW_S == (N+4)'(u4_ff) * K_UW_S);
      end
   end

   // ---------------- stage 6: full products ----------------
   logic signed [PW-1:0] p6_ff [4];
   logic                 degen6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            p6_ff[k] <= (PW'(hh_ff[k]) <<< (2 * S))
                      + ((PW'(hl_ff[k]) + PW'(lh_ff[k])) <<< S)
                      + $signed(PW'(ll_ff[k]));
         end
         degen6_ff <= degen5_ff;
      end
   end

   // ---------------- stage 7: numerator and denominator ----------------
   logic signed [NW-1:0] num7_ff;
   logic signed [DW-1:0] den7_ff;
   logic                 degen7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num7_ff   <= NW'(p6_ff[0]) * K_NUM;
         den7_ff   <= DW'(p6_ff[1]) * K_UV + DW'(p6_ff[2]) * K_VW - DW'(p6_ff[3]) * K_UW;
         degen7_ff <= degen6_ff;
      end
   end

   // ---------------- stage 8: magnitudes and sign ----------------
   logic [NW-1:0] num8_ff;
   logic [DW-1:0] den8_ff;
   bpc_side_type  side8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num8_ff      <= num7_ff[NW-1] ? NW'(-num7_ff) : NW'(num7_ff);
         den8_ff      <= den7_ff[DW-1] ? DW'(-den7_ff) : DW'(den7_ff);
         side8_ff.neg <= num7_ff[NW-1] ^ den7_ff[DW-1];
         side8_ff.bad <= degen7_ff || (den7_ff == '0);
         side8_ff.sat <= 1'b0;
      end
   end

   // ---------------- divider ----------------
   logic          div_valid;
   logic [QB-1:0] div_quot;
   logic          div_rem_nz;
   bpc_side_type  div_side;

   bpc_div #(
      .NW (NW),
      .DW (DW),
      .QB (QB)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (vld_ff[7]),
      .in_num     (num8_ff),
      .in_den     (den8_ff),
      .in_side    (side8_ff),
      .out_valid  (div_valid),
      .out_quot   (div_quot),
      .out_rem_nz (div_rem_nz),
      .out_side   (div_side)
   );

   // ---------------- response register ----------------
   logic [QB:0]         sum_pos;
   logic [QB:0]         sub_neg;
   logic [QB:0]         diff_neg;
   logic [OUT_BITS-1:0] press_in;
   logic                oor_in;
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] press_ff;
   logic                oor_ff;

   always_comb begin
      // negative quotients round down: borrow one more on a remainder
      sum_pos  = P_BASE_Q + (QB+1)'(div_quot);
      sub_neg  = (QB+1)'(div_quot) + (QB+1)'(div_rem_nz);
      diff_neg = P_BASE_Q - sub_neg;
      press_in = '0;
      oor_in   = 1'b1;
      if (div_side.bad) begin
         press_in = '0;
      end else if (div_side.sat) begin
         press_in = div_side.neg ? '0 : P_MAX[OUT_BITS-1:0];
      end else if (div_side.neg) begin
         if (sub_neg <= P_BASE_Q) begin
            press_in = diff_neg[OUT_BITS-1:0];
            oor_in   = 1'b0;
         end
      end else if (sum_pos > P_MAX) begin
         press_in = P_MAX[OUT_BITS-1:0];
      end else begin
         press_in = sum_pos[OUT_BITS-1:0];
         oor_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         press_ff <= press_in;
         oor_ff   <= oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_pa  = press_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

@@ dv/baro_pressure_compensate_top_tb.sv @@
// Self-checking testbench for the barometric pressure compensation pipeline.
`timescale 1ns / 1ps

class bpc_scoreboard;
   typedef struct {
      logic [17:0] pa;
      logic        oor;
   } bpc_result_type;

   bit [15:0]   coeff [4];
   bpc_result_type pending [$];
   int          mismatches;

   function new();
      foreach (coeff[i]) coeff[i] = bpc_pkg::OTP_RESET;
      mismatches = 0;
   endfunction

   function void set_coeff(int idx, bit [15:0] val);
      coeff[idx] = val;
   endfunction

   // Compute the compensated pressure for one sample.
   function bpc_result_type compensate(bit [15:0] raw_t, bit [23:0] raw_p);
      bpc_result_type  res;
      longint       t, l0, l1, l2, u, v, w;
      longint unsigned tt;
      logic signed [159:0] num, den, q, r;
      logic [159:0] nmag, dmag;
      bit           neg;
      longint       total;
      t  = longint'(raw_t) - 32768;
      tt = t * t;
      l0 = (64'd3670016 << 16) + ((longint'(coeff[0]) * tt) >> 8);
      l1 = ((longint'(coeff[3]) * 2048) << 16) + ((longint'(coeff[1]) * tt) >> 8);
      l2 = (64'd12058624 << 16) + ((longint'(coeff[2]) * tt) >> 8);
      u = l1 - l0;
      v = l2 - l0;
      w = (longint'(raw_p) << 16) - l0;
      res.pa  = '0;
      res.oor = 1'b1;
      if (u == 0 || 7 * v == 12 * u) return res;
      num = 160'(signed'(w)) * 160'(signed'(v - u)) * 420000;
      den = 160'(signed'(5 * u)) * 160'(signed'(v))
          + 160'(signed'(7 * v)) * 160'(signed'(w))
          - 160'(signed'(12 * u)) * 160'(signed'(w));
      if (den == 0) return res;
      neg  = (num < 0) != (den < 0);
      nmag = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      q = nmag / dmag;
      r = nmag % dmag;
      if (q > (160'd1 << 40)) begin
         res.pa = neg ? 18'd0 : 18'h3FFFF;
         return res;
      end
      if (neg) total = 45000 - longint'(q) - (r != 0 ? 1 : 0);
      else total = 45000 + longint'(q);
      if (total < 0) res.pa = 0;
      else if (total > 262143) res.pa = 18'h3FFFF;
      else begin
         res.pa  = total[17:0];
         res.oor = 1'b0;
      end
      return res;
   endfunction

   function void note_sample(bit [15:0] raw_t, bit [23:0] raw_p);
      pending.push_back(compensate(raw_t, raw_p));
   endfunction

   function void check_result(logic [17:0] pa, logic oor);
      bpc_result_type exp_r;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response pa=%0d oor=%0b", pa, oor);
         return;
      end
      exp_r = pending.pop_front();
      if (pa !== exp_r.pa || oor !== exp_r.oor) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp pa=%0d oor=%0b, got pa=%0d oor=%0b",
                     exp_r.pa, exp_r.oor, pa, oor);
      end
   endfunction
endclass

module baro_pressure_compensate_top_tb;
   import bpc_pkg::*;

   localparam int LATENCY = 28;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_raw_temp = '0;
   logic [23:0] req_raw_press = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [17:0] rsp_pressure_pa;
   logic        rsp_out_of_range;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_COEFF_0;
   logic [15:0] csr_wdata = '0;

   bpc_scoreboard pressure_sb = new();

   // Sink control: random stalls unless disabled; hold_cycles forces a long stall.
   bit random_stall = 1'b0;
   int hold_cycles = 0;

   always #6 clock = ~clock;

   baro_pressure_compensate_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_temp     (req_raw_temp),
      .req_raw_press    (req_raw_press),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pressure_pa  (rsp_pressure_pa),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Check every response transaction at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pressure_sb.check_result(rsp_pressure_pa, rsp_out_of_range);
   end

   // Receiver: random ready, with a forced long hold when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= random_stall ? ($urandom_range(99) >= 15) : 1'b1;
      end
   end

   // Offer one request transaction; returns at the falling edge after acceptance.
   // Valid stays up so the next transaction can follow without a gap.
   task automatic send_sample(input bit [15:0] raw_t, input bit [23:0] raw_p);
      if (random_stall) begin
         while ($urandom_range(99) < 15) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_raw_temp  <= raw_t;
      req_raw_press <= raw_p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pressure_sb.note_sample(raw_t, raw_p);
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pressure_sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_coeff(input bpc_csr_type idx, input bit [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pressure_sb.set_coeff(int'(idx), val);
      @(negedge clock);
   endtask

   // Realistic samples sit near the calibration curve; some are pure noise.
   task automatic random_sample();
      if ($urandom_range(9) < 7)
         send_sample(16'(32768 + $urandom_range(16000) - 8000),
                     24'($urandom_range(12000000, 3000000)));
      else
         send_sample(16'($urandom), 24'($urandom));
   endtask

   initial begin
      bit [15:0] cset [4];
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes and special cases at reset calibration.
      send_sample(16'd0, 24'd0);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd32768, 24'd3670016);
      send_sample(16'd32768, 24'd12058624);
      send_sample(16'd32768, 24'd649216);
      send_sample(16'd32768, 24'd0);
      send_sample(16'd32768, 24'hFFFFFF);
      send_sample(16'hAAAA, 24'h555555);
      send_sample(16'h5555, 24'hAAAAAA);
      drain_pipe();

      // Degenerate fit: middle point equals lower point.
      write_coeff(CSR_COEFF_3, 16'd1792);
      write_coeff(CSR_COEFF_0, 16'd0);
      write_coeff(CSR_COEFF_1, 16'd0);
      send_sample(16'd32768, 24'd5000000);
      send_sample(16'd40000, 24'd5000000);
      drain_pipe();
      // Calibration extremes.
      write_coeff(CSR_COEFF_0, 16'hFFFF);
      write_coeff(CSR_COEFF_1, 16'hFFFF);
      write_coeff(CSR_COEFF_2, 16'hFFFF);
      write_coeff(CSR_COEFF_3, 16'hFFFF);
      send_sample(16'd0, 24'd1000000);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd32768, 24'd8000000);
      drain_pipe();

      // Random phases, each with its own calibration set.
      random_stall = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) cset = '{16'd317, 16'd317, 16'd317, 16'd3900};
         else if (ph == 1) cset = '{16'd0, 16'd0, 16'd0, 16'd0};
         else foreach (cset[k]) cset[k] = 16'($urandom);
         write_coeff(CSR_COEFF_0, cset[0]);
         write_coeff(CSR_COEFF_1, cset[1]);
         write_coeff(CSR_COEFF_2, cset[2]);
         write_coeff(CSR_COEFF_3, cset[3]);
         // Phase 2 runs with no idling on either side.
         random_stall = (ph != 2);
         // Phase 3: long receiver hold while requests keep flowing.
         if (ph == 3) hold_cycles = 200;
         for (int n = 0; n < 120; n++) begin
            random_sample();
            // Sender pauses once until all responses are back.
            if (ph == 4 && n == 60)
               drain_pipe();
         end
         drain_pipe();
      end

      if (pressure_sb.mismatches == 0 && pressure_sb.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
